[rtl/aes128_block_cipher_unit_defines.svh]
// assertion macros for the aes128 unit
`ifndef AES128_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define AES128_BLOCK_CIPHER_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define AES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/aes_pkg.sv]
package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned ByteCycles = 16;

    typedef logic [7:0]   t_byte;
    typedef logic [127:0] t_block;
    typedef logic [2:0]   t_cfg_idx;

    typedef enum logic [2:0] {
        CFG_KEY_A_WORD0 = 3'd0,
        CFG_KEY_A_WORD1 = 3'd1,
        CFG_KEY_A_WORD2 = 3'd2,
        CFG_KEY_A_WORD3 = 3'd3,
        CFG_KEY_B_WORD0 = 3'd4,
        CFG_KEY_B_WORD1 = 3'd5,
        CFG_KEY_B_WORD2 = 3'd6,
        CFG_KEY_B_WORD3 = 3'd7
    } t_cfg_reg;

    // control from the sequencer to the byte datapath
    typedef struct packed {
        logic load;
        logic shift;     // byte shift; the state path shifts on sub_byte, not on this bit
        logic sub_byte;  // substitute the byte leaving the shift line
        logic mix;       // mix columns and add round key on whole state
        logic last;      // final round, no mix
        logic key_step;  // advance round key
        logic decrypt;
    } t_ctrl;

    function automatic t_byte xtime(input t_byte x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte gmul(input t_byte a, input logic [3:0] b);
        t_byte p;
        t_byte t;
        p = '0;
        t = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ t;
            t = xtime(t);
        end
        gmul = p;
    endfunction

    function automatic t_byte sbox_fwd(input t_byte x);
        logic [7:0] tbl [256];
        tbl = '{
        8'd99,8'd124,8'd119,8'd123,8'd242,8'd107,8'd111,8'd197,8'd48,8'd1,8'd103,8'd43,8'd254,8'd215,8'd171,8'd118,
        8'd202,8'd130,8'd201,8'd125,8'd250,8'd89,8'd71,8'd240,8'd173,8'd212,8'd162,8'd175,8'd156,8'd164,8'd114,8'd192,
        8'd183,8'd253,8'd147,8'd38,8'd54,8'd63,8'd247,8'd204,8'd52,8'd165,8'd229,8'd241,8'd113,8'd216,8'd49,8'd21,
        8'd4,8'd199,8'd35,8'd195,8'd24,8'd150,8'd5,8'd154,8'd7,8'd18,8'd128,8'd226,8'd235,8'd39,8'd178,8'd117,
        8'd9,8'd131,8'd44,8'd26,8'd27,8'd110,8'd90,8'd160,8'd82,8'd59,8'd214,8'd179,8'd41,8'd227,8'd47,8'd132,
        8'd83,8'd209,8'd0,8'd237,8'd32,8'd252,8'd177,8'd91,8'd106,8'd203,8'd190,8'd57,8'd74,8'd76,8'd88,8'd207,
        8'd208,8'd239,8'd170,8'd251,8'd67,8'd77,8'd51,8'd133,8'd69,8'd249,8'd2,8'd127,8'd80,8'd60,8'd159,8'd168,
        8'd81,8'd163,8'd64,8'd143,8'd146,8'd157,8'd56,8'd245,8'd188,8'd182,8'd218,8'd33,8'd16,8'd255,8'd243,8'd210,
        8'd205,8'd12,8'd19,8'd236,8'd95,8'd151,8'd68,8'd23,8'd196,8'd167,8'd126,8'd61,8'd100,8'd93,8'd25,8'd115,
        8'd96,8'd129,8'd79,8'd220,8'd34,8'd42,8'd144,8'd136,8'd70,8'd238,8'd184,8'd20,8'd222,8'd94,8'd11,8'd219,
        8'd224,8'd50,8'd58,8'd10,8'd73,8'd6,8'd36,8'd92,8'd194,8'd211,8'd172,8'd98,8'd145,8'd149,8'd228,8'd121,
        8'd231,8'd200,8'd55,8'd109,8'd141,8'd213,8'd78,8'd169,8'd108,8'd86,8'd244,8'd234,8'd101,8'd122,8'd174,8'd8,
        8'd186,8'd120,8'd37,8'd46,8'd28,8'd166,8'd180,8'd198,8'd232,8'd221,8'd116,8'd31,8'd75,8'd189,8'd139,8'd138,
        8'd112,8'd62,8'd181,8'd102,8'd72,8'd3,8'd246,8'd14,8'd97,8'd53,8'd87,8'd185,8'd134,8'd193,8'd29,8'd158,
        8'd225,8'd248,8'd152,8'd17,8'd105,8'd217,8'd142,8'd148,8'd155,8'd30,8'd135,8'd233,8'd206,8'd85,8'd40,8'd223,
        8'd140,8'd161,8'd137,8'd13,8'd191,8'd230,8'd66,8'd104,8'd65,8'd153,8'd45,8'd15,8'd176,8'd84,8'd187,8'd22};
        sbox_fwd = tbl[x];
    endfunction

    function automatic t_byte sbox_inv(input t_byte x);
        logic [7:0] tbl [256];
        tbl = '{
        8'd82,8'd9,8'd106,8'd213,8'd48,8'd54,8'd165,8'd56,8'd191,8'd64,8'd163,8'd158,8'd129,8'd243,8'd215,8'd251,
        8'd124,8'd227,8'd57,8'd130,8'd155,8'd47,8'd255,8'd135,8'd52,8'd142,8'd67,8'd68,8'd196,8'd222,8'd233,8'd203,
        8'd84,8'd123,8'd148,8'd50,8'd166,8'd194,8'd35,8'd61,8'd238,8'd76,8'd149,8'd11,8'd66,8'd250,8'd195,8'd78,
        8'd8,8'd46,8'd161,8'd102,8'd40,8'd217,8'd36,8'd178,8'd118,8'd91,8'd162,8'd73,8'd109,8'd139,8'd209,8'd37,
        8'd114,8'd248,8'd246,8'd100,8'd134,8'd104,8'd152,8'd22,8'd212,8'd164,8'd92,8'd204,8'd93,8'd101,8'd182,8'd146,
        8'd108,8'd112,8'd72,8'd80,8'd253,8'd237,8'd185,8'd218,8'd94,8'd21,8'd70,8'd87,8'd167,8'd141,8'd157,8'd132,
        8'd144,8'd216,8'd171,8'd0,8'd140,8'd188,8'd211,8'd10,8'd247,8'd228,8'd88,8'd5,8'd184,8'd179,8'd69,8'd6,
        8'd208,8'd44,8'd30,8'd143,8'd202,8'd63,8'd15,8'd2,8'd193,8'd175,8'd189,8'd3,8'd1,8'd19,8'd138,8'd107,
        8'd58,8'd145,8'd17,8'd65,8'd79,8'd103,8'd220,8'd234,8'd151,8'd242,8'd207,8'd206,8'd240,8'd180,8'd230,8'd115,
        8'd150,8'd172,8'd116,8'd34,8'd231,8'd173,8'd53,8'd133,8'd226,8'd249,8'd55,8'd232,8'd28,8'd117,8'd223,8'd110,
        8'd71,8'd241,8'd26,8'd113,8'd29,8'd41,8'd197,8'd137,8'd111,8'd183,8'd98,8'd14,8'd170,8'd24,8'd190,8'd27,
        8'd252,8'd86,8'd62,8'd75,8'd198,8'd210,8'd121,8'd32,8'd154,8'd219,8'd192,8'd254,8'd120,8'd205,8'd90,8'd244,
        8'd31,8'd221,8'd168,8'd51,8'd136,8'd7,8'd199,8'd49,8'd177,8'd18,8'd16,8'd89,8'd39,8'd128,8'd236,8'd95,
        8'd96,8'd81,8'd127,8'd169,8'd25,8'd181,8'd74,8'd13,8'd45,8'd229,8'd122,8'd159,8'd147,8'd201,8'd156,8'd239,
        8'd160,8'd224,8'd59,8'd77,8'd174,8'd42,8'd245,8'd176,8'd200,8'd235,8'd187,8'd60,8'd131,8'd83,8'd153,8'd97,
        8'd23,8'd43,8'd4,8'd126,8'd186,8'd119,8'd214,8'd38,8'd225,8'd105,8'd20,8'd99,8'd85,8'd33,8'd12,8'd125};
        sbox_inv = tbl[x];
    endfunction

endpackage

[rtl/aes_key_sched.sv]
// round key generator: one s-box per cycle while i_sub_en is set, over the rotated last word
module aes_key_sched (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_decrypt,
    input  aes_pkg::t_block      i_key,
    input  logic                 i_sub_en,
    input  logic [1:0]           i_sub_sel,
    input  logic                 i_step,
    output aes_pkg::t_block      o_round_key
);
    aes_pkg::t_block r_key;
    aes_pkg::t_byte  r_rcon;
    logic [31:0]     r_sub;
    logic [31:0]     w0, w1, w2, w3, t;
    logic [31:0]     nw0, nw1, nw2, nw3;
    logic [31:0]     rot;
    aes_pkg::t_byte  sel_byte;
    aes_pkg::t_byte  rcon_prev, rcon_use;

    assign w0 = r_key[127:96];
    assign w1 = r_key[95:64];
    assign w2 = r_key[63:32];
    assign w3 = r_key[31:0];

    // forward: bytes of rotword of w3; reverse: of w3 ^ w2 (the previous w3)
    assign t   = i_decrypt ? (w3 ^ w2) : w3;
    assign rot = {t[23:0], t[31:24]};

    // reverse walk steps rcon back by one before using it
    assign rcon_prev = r_rcon[0] ? {1'b1, r_rcon[7:1] ^ 7'h0d} : {1'b0, r_rcon[7:1]};
    assign rcon_use  = i_decrypt ? rcon_prev : r_rcon;

    always_comb begin
        case (i_sub_sel)
            2'd0:    sel_byte = rot[31:24];
            2'd1:    sel_byte = rot[23:16];
            2'd2:    sel_byte = rot[15:8];
            default: sel_byte = rot[7:0];
        endcase
    end

    always_comb begin
        if (!i_decrypt) begin
            nw0 = w0 ^ r_sub ^ {rcon_use, 24'h0};
            nw1 = w1 ^ nw0;
            nw2 = w2 ^ nw1;
            nw3 = w3 ^ nw2;
        end else begin
            nw3 = w3 ^ w2;
            nw2 = w2 ^ w1;
            nw1 = w1 ^ w0;
            nw0 = w0 ^ r_sub ^ {rcon_use, 24'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcon <= 8'h01;
        end else if (i_load) begin
            r_rcon <= 8'h01;
        end else if (i_step) begin
            r_rcon <= i_decrypt ? rcon_prev : aes_pkg::xtime(r_rcon);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= i_key;
        end else if (i_step) begin
            r_key <= {nw0, nw1, nw2, nw3};
        end
        if (i_sub_en) begin
            r_sub <= {r_sub[23:0], aes_pkg::sbox_fwd(sel_byte)};
        end
    end

    assign o_round_key = r_key;
endmodule

[rtl/aes_state_path.sv]
// state shift line: one s-box byte per cycle while sub_byte is set, column mix per round but the last
module aes_state_path (
    input  logic            i_clk,
    input  aes_pkg::t_ctrl  i_ctrl,
    input  aes_pkg::t_block i_data,
    input  aes_pkg::t_block i_round_key,
    output aes_pkg::t_block o_state
);
    aes_pkg::t_block r_state;
    aes_pkg::t_byte  out_byte, sub_byte;
    aes_pkg::t_block shifted, mixed, row_fix, pre;

    assign out_byte = r_state[127:120];
    assign sub_byte = i_ctrl.decrypt ? aes_pkg::sbox_inv(out_byte)
                                     : aes_pkg::sbox_fwd(out_byte);

    // byte permutation for shift rows (applied once after 16 substitutions)
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_ctrl.decrypt)
                    row_fix[127 - 8*(r + 4*((c + r) % 4)) -: 8] =
                        r_state[127 - 8*(r + 4*c) -: 8];
                else
                    row_fix[127 - 8*(r + 4*c) -: 8] =
                        r_state[127 - 8*(r + 4*((c + r) % 4)) -: 8];
            end
        end
    end

    always_comb begin
        // decrypt: add key then inverse mix; encrypt: mix then add key
        pre = i_ctrl.decrypt ? (row_fix ^ i_round_key) : row_fix;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                mixed[127 - 8*(4*c + r) -: 8] = '0;
                for (int k = 0; k < 4; k++) begin
                    mixed[127 - 8*(4*c + r) -: 8] = mixed[127 - 8*(4*c + r) -: 8] ^
                        aes_pkg::gmul(pre[127 - 8*(4*c + k) -: 8],
                            i_ctrl.decrypt ?
                                (((k - r + 4) % 4) == 0 ? 4'd14 :
                                 ((k - r + 4) % 4) == 1 ? 4'd11 :
                                 ((k - r + 4) % 4) == 2 ? 4'd13 : 4'd9) :
                                (((k - r + 4) % 4) == 0 ? 4'd2 :
                                 ((k - r + 4) % 4) == 1 ? 4'd3 : 4'd1));
                end
            end
        end
    end

    assign shifted = {r_state[119:0], sub_byte};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_state <= i_data ^ i_round_key;
        end else if (i_ctrl.sub_byte) begin
            r_state <= shifted;
        end else if (i_ctrl.last) begin
            r_state <= row_fix ^ i_round_key;
        end else if (i_ctrl.mix) begin
            r_state <= i_ctrl.decrypt ? mixed : (mixed ^ i_round_key);
        end
    end

    assign o_state = r_state;
endmodule

[rtl/aes128_block_cipher_unit.sv]
// channel   | handshake           | payload
// ----------+---------------------+-------------------------------------------
// input     | i_valid / o_ready   | i_req_type, i_key_select, i_data_word0..3
// output    | o_valid / i_ready   | o_result_word0..3
// config    | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one block at a time; after the first add round key, each round feeds the
// state bytes one by one through one s-box (the key s-box takes the four
// rotated key bytes alongside the first of them), then does shift rows, mix
// columns and round key (no mix in the last round)
// decrypt first walks the key schedule forward 10 steps; the result then
// waits in the output register; the next word is taken once the result leaves
// reset is synchronous, active low, and clears keys and control
`include "aes128_block_cipher_unit_defines.svh"

module aes128_block_cipher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic        i_key_select,
    input  logic [31:0] i_data_word0,
    input  logic [31:0] i_data_word1,
    input  logic [31:0] i_data_word2,
    input  logic [31:0] i_data_word3,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_word0,
    output logic [31:0] o_result_word1,
    output logic [31:0] o_result_word2,
    output logic [31:0] o_result_word3,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_KFWD   = 6'b000010,  // decrypt: run schedule to the last key
        ST_LOAD   = 6'b000100,  // first add round key
        ST_SUB    = 6'b001000,  // byte-serial substitution
        ST_MIX    = 6'b010000,  // shift rows, mix, add key
        ST_OUT    = 6'b100000
    } t_state;

    t_state          r_st, n_st;
    logic [31:0]     r_key [8];
    logic            r_dec;
    aes_pkg::t_block r_data;
    logic [3:0]      r_round;
    logic [4:0]      r_cnt;
    aes_pkg::t_ctrl  ctrl;
    aes_pkg::t_block round_key, state, key_sel;
    logic            ks_load, ks_sub_en, ks_step, ks_dec;
    logic [1:0]      ks_sub_sel;
    logic            accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_st == ST_IDLE);
    assign o_valid     = (r_st == ST_OUT);
    assign accept      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_key[i] <= '0;
        end else if (i_cfg_valid) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    // key picked from the incoming word; decrypt always takes key b
    assign key_sel = (i_req_type | i_key_select) ? {r_key[4], r_key[5], r_key[6], r_key[7]}
                                                 : {r_key[0], r_key[1], r_key[2], r_key[3]};

    // key schedule direction: forward while winding up or encrypting
    assign ks_dec    = r_dec && (r_st != ST_KFWD);
    assign ks_load   = (r_st == ST_IDLE) && accept;
    assign ks_sub_sel = r_cnt[1:0];
    // key s-box while r_cnt is below 4, key step at r_cnt 4, ready for the mix
    always_comb begin
        ks_sub_en = 1'b0;
        ks_step   = 1'b0;
        case (r_st)
            ST_KFWD, ST_SUB: begin
                ks_sub_en = (r_cnt < 5'd4);
                ks_step   = (r_cnt == 5'd4);
            end
            default: ;
        endcase
    end

    aes_key_sched u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ks_load),
        .i_decrypt  (ks_dec),
        .i_key      (key_sel),
        .i_sub_en   (ks_sub_en),
        .i_sub_sel  (ks_sub_sel),
        .i_step     (ks_step),
        .o_round_key(round_key)
    );

    always_comb begin
        ctrl          = '0;
        ctrl.decrypt  = r_dec;
        ctrl.load     = (r_st == ST_LOAD);
        ctrl.sub_byte = (r_st == ST_SUB);
        ctrl.shift    = (r_st == ST_SUB);
        ctrl.mix      = (r_st == ST_MIX) && (r_round != 4'(aes_pkg::NumRounds));
        ctrl.last     = (r_st == ST_MIX) && (r_round == 4'(aes_pkg::NumRounds));
        ctrl.key_step = ks_step;
    end

    aes_state_path u_path (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl),
        .i_data     (r_data),
        .i_round_key(round_key),
        .o_state    (state)
    );

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (accept) n_st = i_req_type ? ST_KFWD : ST_LOAD;
            ST_KFWD: if (r_cnt == 5'd4 && r_round == 4'd9) n_st = ST_LOAD;
            ST_LOAD: n_st = ST_SUB;
            ST_SUB:  if (r_cnt == 5'(aes_pkg::ByteCycles - 1)) n_st = ST_MIX;
            ST_MIX:  n_st = (r_round == 4'(aes_pkg::NumRounds)) ? ST_OUT : ST_SUB;
            ST_OUT:  if (i_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_cnt   <= '0;
            r_round <= '0;
            r_dec   <= 1'b0;
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_IDLE: begin
                    r_cnt   <= '0;
                    r_round <= '0;
                    if (accept) begin
                        r_dec   <= i_req_type;
                    end
                end
                ST_KFWD: begin
                    r_cnt <= (r_cnt == 5'd4) ? 5'd0 : r_cnt + 5'd1;
                    if (r_cnt == 5'd4)
                        r_round <= (r_round == 4'd9) ? 4'd0 : r_round + 4'd1;
                end
                ST_LOAD: begin
                    r_cnt   <= '0;
                    r_round <= 4'd1;
                end
                ST_SUB:  r_cnt <= r_cnt + 5'd1;
                ST_MIX: begin
                    r_cnt   <= '0;
                    r_round <= r_round + 4'd1;
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_data <= {i_data_word0, i_data_word1, i_data_word2, i_data_word3};
    end

    assign o_result_word0 = state[127:96];
    assign o_result_word1 = state[95:64];
    assign o_result_word2 = state[63:32];
    assign o_result_word3 = state[31:0];

    `AES_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(state), "result changed while stalled")
    `AES_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, o_valid, !o_ready, "input taken while result pending")
    `AES_ASSERT_NXT(a_round_range, i_clk, i_rst_n, r_st == ST_MIX, r_round <= 4'(aes_pkg::NumRounds + 1), "round count overran")
endmodule

[bench/aes128_block_cipher_unit_tb.sv]
module aes128_block_cipher_unit_tb;
    import aes_pkg::*;

    localparam int unsigned CycleLimit  = 3000000;
    localparam int unsigned DrainCycles = 300;
    localparam int unsigned HoldOff     = 4000;
    localparam logic        ReqEncrypt  = 1'b0;
    localparam logic        ReqDecrypt  = 1'b1;
    localparam logic        UseKeyA     = 1'b0;
    localparam logic        UseKeyB     = 1'b1;

    // scoreboard: aes-128 predictor plus the queue of blocks still owed
    class cipher_scoreboard;
        logic [31:0] keys [8];
        t_block      owed_blocks [$];
        t_byte       fwd [256];
        t_byte       inv [256];

        function new();
            t_byte b;
            t_byte s;
            for (int x = 0; x < 256; x++) begin
                b = 8'h00;
                for (int y = 1; y < 256; y++)
                    if (gf_mul(t_byte'(x), t_byte'(y)) == 8'h01) b = t_byte'(y);
                s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                    ^ {b[3:0], b[7:4]} ^ 8'h63;
                fwd[x] = s;
                inv[s] = t_byte'(x);
            end
            foreach (keys[i]) keys[i] = '0;
        endfunction

        function t_byte gf_mul(t_byte a, t_byte b);
            t_byte p;
            p = '0;
            for (int i = 0; i < 8; i++) begin
                if (b[i]) p = p ^ a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return p;
        endfunction

        function t_block cipher(logic dec, logic key_sel, t_block din);
            logic [31:0] w [44];
            logic [31:0] t;
            t_byte       st [16];
            t_byte       tmp [16];
            t_byte       col [4];
            t_byte       rcon;
            t_byte       m [4];
            t_block      dout;
            int          base;
            base = (dec || key_sel) ? 4 : 0;
            rcon = 8'h01;
            for (int i = 0; i < 4; i++) w[i] = keys[base + i];
            for (int i = 4; i < 44; i++) begin
                t = w[i-1];
                if (i % 4 == 0) begin
                    t = {t[23:0], t[31:24]};
                    t = {fwd[t[31:24]], fwd[t[23:16]], fwd[t[15:8]], fwd[t[7:0]]}
                        ^ {rcon, 24'h0};
                    rcon = gf_mul(rcon, 8'h02);
                end
                w[i] = w[i-4] ^ t;
            end
            for (int i = 0; i < 16; i++) st[i] = din[127 - 8*i -: 8];
            for (int step = 0; step <= 10; step++) begin
                int rk;
                rk = dec ? 10 - step : step;
                if (step > 0) begin
                    // sub bytes with shift rows, forward or inverse
                    for (int r = 0; r < 4; r++)
                        for (int c = 0; c < 4; c++)
                            if (dec) tmp[r + 4*((c + r) % 4)] = inv[st[r + 4*c]];
                            else     tmp[r + 4*c] = fwd[st[r + 4*((c + r) % 4)]];
                    st = tmp;
                    // encrypt mixes before the round key, decrypt after
                    if (!dec && step < 10) begin
                        m = '{8'd2, 8'd3, 8'd1, 8'd1};
                        for (int c = 0; c < 4; c++) begin
                            for (int r = 0; r < 4; r++) col[r] = st[4*c + r];
                            for (int r = 0; r < 4; r++) begin
                                st[4*c + r] = 8'h00;
                                for (int k = 0; k < 4; k++)
                                    st[4*c + r] ^= gf_mul(col[k], m[(k - r + 4) % 4]);
                            end
                        end
                    end
                end
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        st[4*c + r] ^= w[4*rk + c][31 - 8*r -: 8];
                if (dec && step > 0 && step < 10) begin
                    m = '{8'd14, 8'd11, 8'd13, 8'd9};
                    for (int c = 0; c < 4; c++) begin
                        for (int r = 0; r < 4; r++) col[r] = st[4*c + r];
                        for (int r = 0; r < 4; r++) begin
                            st[4*c + r] = 8'h00;
                            for (int k = 0; k < 4; k++)
                                st[4*c + r] ^= gf_mul(col[k], m[(k - r + 4) % 4]);
                        end
                    end
                end
            end
            for (int i = 0; i < 16; i++) dout[127 - 8*i -: 8] = st[i];
            return dout;
        endfunction

        function void note_block(logic dec, logic key_sel, t_block din);
            owed_blocks.push_back(cipher(dec, key_sel, din));
        endfunction

        // returns -1 with nothing owed, else a mask of wrong words
        function int check_block(t_block got, output t_block want);
            int mask;
            want = '0;
            if (owed_blocks.size() == 0) return -1;
            want = owed_blocks.pop_front();
            mask = 0;
            for (int i = 0; i < 4; i++)
                if (got[127 - 32*i -: 32] !== want[127 - 32*i -: 32]) mask |= 1 << i;
            return mask;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_req_type;
    logic        i_key_select;
    logic [31:0] i_data_word0;
    logic [31:0] i_data_word1;
    logic [31:0] i_data_word2;
    logic [31:0] i_data_word3;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_result_word0;
    logic [31:0] o_result_word1;
    logic [31:0] o_result_word2;
    logic [31:0] o_result_word3;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    cipher_scoreboard sb;
    int unsigned      error_count;
    int unsigned      cycle_count;
    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    int unsigned      hold_request;

    aes128_block_cipher_unit u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %08h expected %08h", what, got, want);
        error_count++;
    endtask

    // output side: check each accepted word, then pick next ready
    initial begin
        int unsigned hold_left;
        int          mask;
        t_block      got;
        t_block      want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = {o_result_word0, o_result_word1, o_result_word2, o_result_word3};
                mask = sb.check_block(got, want);
                if (mask < 0) report("unexpected word", got[127:96], 32'h0);
                else
                    for (int i = 0; i < 4; i++)
                        if (mask[i])
                            report($sformatf("result_word%0d", i),
                                   got[127 - 32*i -: 32], want[127 - 32*i -: 32]);
            end
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                // long stall so the block fills and backs up its input
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_block(logic req, logic key_sel, t_block blk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_key_select <= key_sel;
        i_data_word0 <= blk[127:96];
        i_data_word1 <= blk[95:64];
        i_data_word2 <= blk[63:32];
        i_data_word3 <= blk[31:0];
        do @(posedge i_clk); while (!o_ready);
        sb.note_block(req, key_sel, blk);
    endtask

    // only called with the block idle; walks all eight key registers
    task automatic load_keys(t_block key_a, t_block key_b);
        t_cfg_reg    r;
        logic [31:0] word;
        r = r.first();
        for (int n = 0; n < 8; n++) begin
            word = (n < 4) ? key_a[127 - 32*n -: 32] : key_b[127 - 32*(n-4) -: 32];
            i_cfg_valid <= 1'b1;
            i_cfg_index <= r;
            i_cfg_data  <= word;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.keys[n] = word;
            r = r.next();
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (sb.owed_blocks.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic t_block rand_block();
        t_block b;
        case ($urandom_range(9))
            0:       b = '0;
            1:       b = '1;
            default: b = {$urandom, $urandom, $urandom, $urandom};
        endcase
        return b;
    endfunction

    task automatic random_blocks(int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_block(logic'($urandom_range(1)), logic'($urandom_range(1)), rand_block());
    endtask

    initial begin
        t_block fips_plain;
        t_block fips_key_a;
        t_block fips_key_b;
        sb             = new();
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_ready        <= 1'b0;
        i_req_type     <= ReqEncrypt;
        i_key_select   <= UseKeyA;
        i_data_word0   <= '0;
        i_data_word1   <= '0;
        i_data_word2   <= '0;
        i_data_word3   <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_KEY_A_WORD0;
        i_cfg_data     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // keys still at their reset value of zero
        send_block(ReqEncrypt, UseKeyA, '0);
        send_block(ReqEncrypt, UseKeyB, '1);
        send_block(ReqDecrypt, UseKeyA, '0);
        drain();

        // standard vectors; decrypt ignores key select and always takes key b
        fips_plain = 128'h00112233445566778899aabbccddeeff;
        fips_key_a = 128'h000102030405060708090a0b0c0d0e0f;
        fips_key_b = 128'h2b7e151628aed2a6abf7158809cf4f3c;
        load_keys(fips_key_a, fips_key_b);
        send_block(ReqEncrypt, UseKeyA, fips_plain);
        send_block(ReqEncrypt, UseKeyB, 128'h3243f6a8885a308d313198a2e0370734);
        send_block(ReqDecrypt, UseKeyB, 128'h3925841d02dc09fbdc118597196a0b32);
        send_block(ReqDecrypt, UseKeyA, 128'h3925841d02dc09fbdc118597196a0b32);
        send_block(ReqDecrypt, UseKeyB, 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
        send_block(ReqEncrypt, UseKeyA, '1);
        send_block(ReqDecrypt, UseKeyB, '1);
        send_block(ReqEncrypt, UseKeyB, {4{32'h5555aaaa}});
        send_block(ReqDecrypt, UseKeyA, {4{32'haaaa5555}});
        for (int i = 0; i < 4; i++)
            send_block(ReqEncrypt, logic'(i % 2), 128'h1 << (32*i + 31));
        drain();

        // extreme keys, no idling
        load_keys('1, '1);
        send_block(ReqEncrypt, UseKeyA, '0);
        send_block(ReqDecrypt, UseKeyB, '0);
        random_blocks(200);
        drain();

        // random keys, sender idles a lot, then the long receiver hold-off
        load_keys({$urandom, $urandom, $urandom, $urandom},
                  {$urandom, $urandom, $urandom, $urandom});
        send_idle_pct = 55;
        random_blocks(250);
        send_idle_pct = 0;
        hold_request  = HoldOff;
        random_blocks(30);
        drain();

        // key a zero, key b random; receiver stalls
        load_keys('0, {$urandom, $urandom, $urandom, $urandom});
        recv_stall_pct = 55;
        random_blocks(300);
        drain();

        // both sides idle now and then
        load_keys({$urandom, $urandom, $urandom, $urandom}, '1);
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        random_blocks(330);
        drain();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[aes128_block_cipher_unit.f]
+incdir+rtl
rtl/aes_pkg.sv
rtl/aes_key_sched.sv
rtl/aes_state_path.sv
rtl/aes128_block_cipher_unit.sv
bench/aes128_block_cipher_unit_tb.sv
